// ===== hdl/pawt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pawt_pkg
// Shared types and codes of the packet acknowledge window tracker.
// ----------------------------------------------------------------------------
package pawt_pkg;

	localparam int ID_W   = 32;
	localparam int MASK_W = 32;

	typedef logic [ID_W-1:0]   id_t;
	typedef logic [MASK_W-1:0] mask_t;

	// request kinds carried on s_axis_tuser
	typedef enum logic {
		OP_ACK   = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	localparam id_t NEWEST_INIT = '1;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_DIV,
		ST_WR,
		ST_RD,
		ST_DRAIN,
		ST_OUT
	} state_t;

endpackage

// ===== hdl/packet_ack_window_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_ack_window_tracker_top
// Ring of acknowledged packet ids with a serial window scan.
//
// Requests enter on s_axis: tuser is the kind (acknowledge or clear), tdata the
// packet id. Each request gives one result on m_axis: the newest id and a mask
// whose bit i is set when id newest-1-i sits in its ring slot.
// An acknowledge writes its id into its ring slot and then scans the window.
// When DEPTH is not a power of two, a multiply by the reciprocal of DEPTH
// first forms id mod DEPTH. The window scan reads one ring slot a cycle from
// the single-port slot memory, which sets the bulk of the latency.
// A clear sweeps the memory, one slot a cycle, and then scans the window.
// One request is worked at a time; s_axis_tready is high only when idle.
// After reset the same sweep runs with tready low.
// The result sits in an output register, so a stalled receiver does not stop
// the next request from being accepted and worked; only the hand-off of the
// following result waits until the register is free.
// ----------------------------------------------------------------------------
module packet_ack_window_tracker_top #(
	parameter int DEPTH  = 1024,
	parameter int WINDOW = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  pawt_pkg::id_t         s_axis_tdata,   // [31:0] packet_id
	input  logic                  s_axis_tuser,   // [0] opcode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [63:0]           m_axis_tdata    // [31:0] recent_ack, [63:32] ack_mask
);
	import pawt_pkg::*;

	localparam int  ABITS     = $clog2(DEPTH);
	localparam bit  POW2      = (DEPTH & (DEPTH - 1)) == 0;
	localparam int unsigned INIT_SLOT = 32'hFFFF_FFFF % DEPTH;
	localparam int  CW        = $clog2(WINDOW) + 1;
	localparam int  MSH       = ID_W + ABITS;
	localparam logic [63:0] RECIP =
		((64'd1 << MSH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);

	typedef logic [ABITS-1:0] slot_t;

	state_t state_q, state_d;

	logic [ID_W-1:0] mem [DEPTH];
	id_t   rdata_q;
	logic  mem_we;
	slot_t mem_addr;
	id_t   mem_wdata;

	id_t   id_q;
	id_t   quo_q;
	slot_t rem_q;
	logic  div_cnt_q;
	logic  clr_report_q;
	slot_t clr_cnt_q;

	id_t   newest_q;
	slot_t nslot_q;
	id_t   cmp_id_q;
	slot_t rd_slot_q;
	logic [CW-1:0] rd_cnt_q;
	id_t   cmp_id_s1;
	logic  vld_s1;
	mask_t mask_q;

	logic  m_valid_q;
	logic [63:0] m_data_q;

	logic  accept, load_out;
	slot_t slot, nslot_new, qd_lo;
	logic [64:0] prod;
	id_t   diff, newest_new;
	logic  adv;

	function automatic slot_t slot_dec(input slot_t s);
		slot_dec = (s == '0) ? slot_t'(DEPTH - 1) : slot_t'(s - 1'b1);
	endfunction

	// slot of id-1, given id and its slot
	function automatic slot_t slot_prev(input id_t id, input slot_t s);
		slot_prev = (id == '0) ? slot_t'(INIT_SLOT) : slot_dec(s);
	endfunction

	assign accept  = s_axis_tvalid && s_axis_tready;
	assign prod    = 65'(id_q) * 65'(RECIP[32:0]);
	assign qd_lo   = slot_t'(quo_q[ABITS-1:0] * slot_t'(DEPTH));
	assign slot    = POW2 ? id_q[ABITS-1:0] : rem_q;
	assign diff    = id_q - newest_q;
	assign adv     = (diff != '0) && !diff[ID_W-1];
	assign newest_new = adv ? id_q : newest_q;
	assign nslot_new  = adv ? slot : nslot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		mem_we        = 1'b0;
		mem_addr      = rd_slot_q;
		mem_wdata     = '0;
		load_out      = 1'b0;
		case (state_q)
			ST_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_cnt_q;
				if (clr_cnt_q == slot_t'(DEPTH - 1)) begin
					state_d = clr_report_q ? ST_RD : ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (s_axis_tuser == OP_CLEAR) state_d = ST_CLR;
					else if (POW2) state_d = ST_WR;
					else state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_cnt_q) state_d = ST_WR;
			end
			ST_WR: begin
				mem_we    = 1'b1;
				mem_addr  = slot;
				mem_wdata = id_q;
				state_d   = ST_RD;
			end
			ST_RD: begin
				if (rd_cnt_q == CW'(WINDOW - 1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!m_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		rdata_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_report_q <= 1'b0;
			clr_cnt_q    <= '0;
			newest_q     <= NEWEST_INIT;
			nslot_q      <= slot_t'(INIT_SLOT);
			div_cnt_q    <= 1'b0;
			rd_cnt_q     <= '0;
			vld_s1       <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_RD);
			case (state_q)
				ST_CLR: begin
					if (clr_cnt_q == slot_t'(DEPTH - 1)) begin
						clr_cnt_q <= '0;
						newest_q  <= NEWEST_INIT;
						nslot_q   <= slot_t'(INIT_SLOT);
						rd_cnt_q  <= '0;
					end else begin
						clr_cnt_q <= slot_t'(clr_cnt_q + 1'b1);
					end
				end
				ST_IDLE: begin
					div_cnt_q <= 1'b0;
					if (accept) clr_report_q <= (s_axis_tuser == OP_CLEAR);
				end
				ST_DIV: begin
					div_cnt_q <= 1'b1;
				end
				ST_WR: begin
					newest_q <= newest_new;
					nslot_q  <= nslot_new;
					rd_cnt_q <= '0;
				end
				ST_RD: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload side of the sequencer
	always_ff @(posedge clk) begin
		cmp_id_s1 <= cmp_id_q;
		case (state_q)
			ST_CLR: begin
				cmp_id_q  <= NEWEST_INIT - 1'b1;
				rd_slot_q <= slot_dec(slot_t'(INIT_SLOT));
				mask_q    <= '0;
			end
			ST_IDLE: begin
				id_q  <= s_axis_tdata;
				rem_q <= '0;
			end
			ST_DIV: begin
				if (!div_cnt_q) quo_q <= id_t'(prod >> MSH);
				else rem_q <= slot_t'(id_q[ABITS-1:0] - qd_lo);
			end
			ST_WR: begin
				cmp_id_q  <= newest_new - 1'b1;
				rd_slot_q <= slot_prev(newest_new, nslot_new);
				mask_q    <= '0;
			end
			ST_RD: begin
				cmp_id_q  <= cmp_id_q - 1'b1;
				rd_slot_q <= slot_prev(cmp_id_q, rd_slot_q);
			end
			default: begin
			end
		endcase
		if (vld_s1) mask_q <= {rdata_q == cmp_id_s1, mask_q[MASK_W-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) m_data_q <= {mask_q >> (MASK_W - WINDOW), newest_q};
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// ===== hdl/pawt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pawt_checker
// Port-level checks of the packet acknowledge window tracker.
// ----------------------------------------------------------------------------
module pawt_checker #(
	parameter int WINDOW = 32
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);
	import pawt_pkg::*;

	localparam logic [63:0] HIGH_MASK = ~((64'd1 << (32 + WINDOW)) - 64'd1);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while busy");

	// no mask bit beyond the window may be set
	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata & HIGH_MASK) == 64'd0)
		else $error("mask bit set beyond window");

endmodule

bind packet_ack_window_tracker_top pawt_checker #(.WINDOW(WINDOW)) u_pawt_checker (.*);
